### hdl/assert_macros.svh
// Assertion macros shared by the RTL of the 48-bit LCG generator.
// Expects signals clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define LCG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define LCG_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

### hdl/lcg48_pkg.sv
// Constants and command codes for the 48-bit LCG generator.
// No dependencies; used by the interfaces, the multiplier and the top level.
`default_nettype none

package lcg48_pkg;

	localparam int STATE_W = 48;
	localparam int SEED_W  = 64;
	localparam int VALUE_W = 64;
	localparam int BOUND_W = 32;
	localparam int CMD_W   = 2;
	localparam int BITS_W  = 6;

	localparam logic [34:0]        LCG_MULT = 35'h5DEECE66D;
	localparam logic [STATE_W-1:0] LCG_INC  = 48'hB;

	// request commands
	localparam logic [CMD_W-1:0] CMD_RAW  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BND  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LONG = 2'd2;
	localparam logic [CMD_W-1:0] CMD_FRAC = 2'd3;

endpackage

`default_nettype wire

### hdl/lcg48_if.sv
// Valid/ready channel interfaces of the 48-bit LCG generator.
// Depends on lcg48_pkg for field widths.
`default_nettype none

interface lcg48_req_if;
	logic                              valid;
	logic                              ready;
	logic [lcg48_pkg::CMD_W-1:0]       command;
	logic [lcg48_pkg::BITS_W-1:0]      bit_count;
	logic signed [lcg48_pkg::BOUND_W-1:0] bound;

	modport source (output valid, command, bit_count, bound, input ready);
	modport sink   (input valid, command, bit_count, bound, output ready);
endinterface

interface lcg48_res_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [lcg48_pkg::VALUE_W-1:0] value;
	logic                                 bad_bound;

	modport source (output valid, value, bad_bound, input ready);
	modport sink   (input valid, value, bad_bound, output ready);
endinterface

interface lcg48_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [lcg48_pkg::SEED_W-1:0]   seed_value;

	modport source (output valid, seed_value, input ready);
	modport sink   (input valid, seed_value, output ready);
endinterface

`default_nettype wire

### hdl/lcg48_random_generator.sv
// Top level of the 48-bit LCG random generator (multiply 0x5DEECE66D, add 11).
// Depends on lcg48_pkg, lcg48_if, lcg48_mul, lcg48_div and assert_macros.svh.
//
// Usage:
//  - cfg: one word writes the seed; the state becomes (seed ^ 0x5DEECE66D) mod 2^48.
//    cfg.ready is high only while no request is in flight.
//  - req: one word per request (command, bit_count, bound). req.ready is high
//    only in the idle state; one request is worked on at a time.
//  - res: one word per request (value, bad_bound), held in an output register.
//    A new request is taken while an old result still waits; if the receiver
//    stalls, the finished result waits in a holding register until the output
//    register frees up.
// Sequence: a state step runs on the shared digit-serial multiplier. A raw draw
//  and a power-of-two bound take one step; long and fraction two chained steps;
//  other bounds a step and a pass of the remainder unit for the first try, and
//  another step and pass for each rejected try. A bound of zero or less answers
//  with bad_bound set, state unchanged. req.ready returns as res.valid rises.
// Reset: state = 0x5DEECE66D, no result pending, ready to accept.
`default_nettype none
`include "assert_macros.svh"

module lcg48_random_generator (
	input  logic          clk,
	input  logic          arst_n,
	lcg48_req_if.sink     req,
	lcg48_res_if.source   res,
	lcg48_cfg_if.sink     cfg
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_DIV  = 4'b0100,
		S_DONE = 4'b1000
	} seq_state_t;

	seq_state_t st_q;

	logic [lcg48_pkg::STATE_W-1:0] state_q;
	logic [lcg48_pkg::CMD_W-1:0]   cmd_q;
	logic [lcg48_pkg::BITS_W-1:0]  bits_q;
	logic [lcg48_pkg::BOUND_W-1:0] bound_q;
	logic                          second_q;   // first of two draws done
	logic [31:0]                   hi_q;       // first draw of long/fraction
	logic [30:0]                   d_q;        // last 31-bit draw
	logic [lcg48_pkg::VALUE_W-1:0] rslt_val_q; // finished result, waiting
	logic                          rslt_bad_q;
	logic                          res_vld_q;
	logic [lcg48_pkg::VALUE_W-1:0] res_val_q;
	logic                          res_bad_q;

	logic                          req_acc;
	logic                          req_bad;
	logic                          pow2;
	logic                          two_draw;
	logic                          mul_start;
	logic [lcg48_pkg::STATE_W-1:0] mul_opnd;
	logic                          mul_done;
	logic [lcg48_pkg::STATE_W-1:0] mul_res;
	logic                          div_start;
	logic                          div_done;
	logic [30:0]                   div_rem;
	logic                          reject;
	logic [31:0]                   chk;
	logic [lcg48_pkg::BITS_W-1:0]  nsat;
	logic [lcg48_pkg::BITS_W-1:0]  shr;
	logic [31:0]                   raw;
	logic [61:0]                   scaled;

	// draws taken from the new state
	logic [31:0] d32;
	logic [30:0] d31;
	logic [26:0] d27;
	logic [25:0] d26;

	assign d32 = mul_res[47:16];
	assign d31 = mul_res[47:17];
	assign d27 = mul_res[47:21];
	assign d26 = mul_res[47:22];

	assign req.ready = (st_q == S_IDLE);
	assign cfg.ready = (st_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;

	// bound of zero or negative on a bounded request
	assign req_bad = (req.command == lcg48_pkg::CMD_BND) &&
		((req.bound == '0) || req.bound[lcg48_pkg::BOUND_W-1]);

	assign pow2     = (bound_q & (bound_q - 32'd1)) == '0;
	assign two_draw = (cmd_q == lcg48_pkg::CMD_LONG) || (cmd_q == lcg48_pkg::CMD_FRAC);

	// rejection test in 32-bit wrapping arithmetic: r - m + (bound - 1)
	assign chk    = {1'b0, d_q} - {1'b0, div_rem} + (bound_q - 32'd1);
	assign reject = chk[31];

	// top bit_count bits, count saturated to 32; zero count gives zero
	assign nsat   = (bits_q > 6'd32) ? 6'd32 : bits_q;
	assign shr    = 6'd32 - nsat;
	assign raw    = d32 >> shr;
	assign scaled = {31'b0, bound_q[30:0]} * {31'b0, d31};

	assign mul_start = (req_acc && !req_bad) ||
		(mul_done && two_draw && !second_q) ||
		(div_done && reject);
	// the chained second draw starts from the fresh product
	assign mul_opnd  = (st_q == S_MUL) ? mul_res : state_q;
	assign div_start = mul_done && (cmd_q == lcg48_pkg::CMD_BND) && !pow2;

	lcg48_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.opnd   (mul_opnd),
		.done   (mul_done),
		.prod   (mul_res)
	);

	lcg48_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (d31),
		.divisor   (bound_q[30:0]),
		.done      (div_done),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			state_q    <= lcg48_pkg::STATE_W'(lcg48_pkg::LCG_MULT);
			cmd_q      <= '0;
			bits_q     <= '0;
			bound_q    <= '0;
			second_q   <= 1'b0;
			hi_q       <= '0;
			d_q        <= '0;
			rslt_val_q <= '0;
			rslt_bad_q <= 1'b0;
			res_vld_q  <= 1'b0;
			res_val_q  <= '0;
			res_bad_q  <= 1'b0;
		end else begin
			if (res_vld_q && res.ready) begin
				res_vld_q <= 1'b0;
			end
			if (cfg.valid && cfg.ready) begin
				state_q <= lcg48_pkg::STATE_W'(cfg.seed_value ^
					{29'b0, lcg48_pkg::LCG_MULT});
			end
			unique case (st_q)
				S_IDLE: begin
					if (req_acc) begin
						cmd_q    <= req.command;
						bits_q   <= req.bit_count;
						bound_q  <= req.bound;
						second_q <= 1'b0;
						if (req_bad) begin
							rslt_val_q <= '0;
							rslt_bad_q <= 1'b1;
							st_q       <= S_DONE;
						end else begin
							st_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					if (mul_done) begin
						state_q    <= mul_res;
						rslt_bad_q <= 1'b0;
						unique case (cmd_q)
							lcg48_pkg::CMD_RAW: begin
								rslt_val_q <= {{32{raw[31]}}, raw};
								st_q       <= S_DONE;
							end
							lcg48_pkg::CMD_BND: begin
								d_q <= d31;
								if (pow2) begin
									rslt_val_q <= {33'b0, scaled[61:31]};
									st_q       <= S_DONE;
								end else begin
									st_q <= S_DIV;
								end
							end
							lcg48_pkg::CMD_LONG: begin
								if (!second_q) begin
									hi_q     <= d32;
									second_q <= 1'b1;
								end else begin
									rslt_val_q <= {hi_q, 32'b0} + {{32{d32[31]}}, d32};
									st_q       <= S_DONE;
								end
							end
							lcg48_pkg::CMD_FRAC: begin
								if (!second_q) begin
									hi_q     <= {6'b0, d26};
									second_q <= 1'b1;
								end else begin
									rslt_val_q <= {11'b0, hi_q[25:0], d27};
									st_q       <= S_DONE;
								end
							end
							default: st_q <= S_DONE;
						endcase
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (reject) begin
							st_q <= S_MUL;
						end else begin
							rslt_val_q <= {33'b0, div_rem};
							st_q       <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (!res_vld_q || res.ready) begin
						res_vld_q <= 1'b1;
						res_val_q <= rslt_val_q;
						res_bad_q <= rslt_bad_q;
						st_q      <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign res.valid     = res_vld_q;
	assign res.value     = res_val_q;
	assign res.bad_bound = res_bad_q;

	`LCG_ASSERT(a_bad_zero, (res.valid && res.bad_bound) |-> (res.value == '0), "bad bound with nonzero value")
	`LCG_ASSERT(a_mul_done_st, mul_done |-> (st_q == S_MUL), "multiplier finished outside step state")
	`LCG_ASSERT(a_div_done_st, div_done |-> (st_q == S_DIV), "divider finished outside remainder state")
	`LCG_ASSERT(a_accept_busy, req_acc |=> (st_q != S_IDLE), "accepted request left sequencer idle")
	`LCG_ASSERT_NEVER(a_start_clash, mul_start && div_start, "multiplier and divider started together")

endmodule

`default_nettype wire

### hdl/lcg48_mul.sv
// Iterative LCG step unit: state * multiplier + increment, mod 2^48.
// One 16-bit digit of the state per cycle. Depends on lcg48_pkg.
`default_nettype none

module lcg48_mul (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [lcg48_pkg::STATE_W-1:0]   opnd,
	output logic                            done,
	output logic [lcg48_pkg::STATE_W-1:0]   prod
);

	localparam logic [1:0] LAST_DIGIT = 2'd2;

	logic [lcg48_pkg::STATE_W-1:0] src_q;
	logic [lcg48_pkg::STATE_W-1:0] acc_q;
	logic [1:0]                    cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [15:0]                   digit;
	logic [50:0]                   pp;
	logic [lcg48_pkg::STATE_W-1:0] part;

	always_comb begin
		unique case (cnt_q)
			2'd0:    digit = src_q[15:0];
			2'd1:    digit = src_q[31:16];
			2'd2:    digit = src_q[47:32];
			default: digit = '0;
		endcase
	end

	assign pp = {35'b0, digit} * {16'b0, lcg48_pkg::LCG_MULT};

	// align the partial product, bits above 47 drop out
	always_comb begin
		unique case (cnt_q)
			2'd0:    part = pp[47:0];
			2'd1:    part = {pp[31:0], 16'b0};
			2'd2:    part = {pp[15:0], 32'b0};
			default: part = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q  <= '0;
			acc_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				src_q  <= opnd;
				acc_q  <= lcg48_pkg::LCG_INC;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				acc_q <= acc_q + part;
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == LAST_DIGIT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

`default_nettype wire

### hdl/lcg48_div.sv
// Restoring remainder unit, 31-bit dividend by 31-bit divisor, one bit a cycle.
// Self-contained; used by the top level for bounded draws.
`default_nettype none

module lcg48_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [30:0] dividend,
	input  logic [30:0] divisor,
	output logic        done,
	output logic [30:0] remainder
);

	localparam int         DW   = 31;
	localparam logic [4:0] LAST = 5'(DW - 1);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvd_q;
	logic [DW-1:0] dsr_q;
	logic [4:0]    cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   shl;
	logic          ge;
	logic [DW-1:0] rem_nxt;

	assign shl     = {rem_q, dvd_q[DW-1]};
	assign ge      = shl >= {1'b0, dsr_q};
	assign rem_nxt = ge ? DW'(shl - {1'b0, dsr_q}) : shl[DW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dvd_q  <= '0;
			dsr_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				dvd_q  <= dividend;
				dsr_q  <= divisor;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= rem_nxt;
				dvd_q <= {dvd_q[DW-2:0], 1'b0};
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire
